@@ design/assert_macros.svh @@
// Assertion helpers used by the display_idle_dim_controller design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/didc_pkg.sv @@
// ----------------------------------------------------------------------------
// didc_pkg
// Types and constants of the display idle/dim controller.
// ----------------------------------------------------------------------------
package didc_pkg;

  localparam int unsigned TimeoutW = 20;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned IdleW    = 32;

  // Request codes
  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_TOUCH_CHK = 3'd1;
  localparam logic [2:0] REQ_WAKE      = 3'd2;
  localparam logic [2:0] REQ_ACTIVITY  = 3'd3;
  localparam logic [2:0] REQ_FORCE_OFF = 3'd4;
  localparam logic [2:0] REQ_FORCE_ON  = 3'd5;

  // Touch controller modes
  localparam logic [1:0] MODE_ACTIVE  = 2'd0;
  localparam logic [1:0] MODE_MONITOR = 2'd1;
  localparam logic [1:0] MODE_SLEEP   = 2'd3;

  // Display change codes
  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_ON   = 2'd1;
  localparam logic [1:0] CHG_OFF  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_BRIGHT  = 1'b1;

  localparam logic [TimeoutW-1:0] TIMEOUT_RST = 20'd30000;
  localparam logic [LevelW-1:0]   BRIGHT_RST  = 8'd100;
  localparam logic [TimeoutW-1:0] MIN_TIMEOUT = 20'd2;
  localparam logic [IdleW-1:0]    TOUCH_DIM_AT = 32'd5000;
  localparam logic [IdleW-1:0]    TOUCH_OFF_AT = 32'd10000;
  localparam logic [IdleW-1:0]    MONITOR_AFTER = 32'd10000;

  typedef struct packed {
    logic [TimeoutW-1:0] display_timeout_ms;
    logic [LevelW-1:0]   user_brightness;
  } didc_cfg_t;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [IdleW-1:0] idle_ms;
    logic             mode_write_ok;
  } didc_item_t;

  typedef struct packed {
    logic              panel_on;
    logic              cycle_is_touch;
    logic [IdleW-1:0]  last_idle_ms;
    logic              is_dimmed;
    logic [LevelW-1:0] saved_brightness;
    logic              touch_monitor_intent;
  } didc_state_t;

  typedef struct packed {
    logic              brightness_write;
    logic [LevelW-1:0] brightness_level;
    logic              touch_mode_write;
    logic [1:0]        touch_mode;
    logic              display_enabled;
    logic [1:0]        display_change;
    logic              idle_restart;
  } didc_result_t;

endpackage

@@ design/didc_if.sv @@
// ----------------------------------------------------------------------------
// didc_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface didc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] idle_ms;
  logic        mode_write_ok;

  modport source (output valid, req_type, idle_ms, mode_write_ok, input ready);
  modport sink   (input valid, req_type, idle_ms, mode_write_ok, output ready);
endinterface

interface didc_out_if;
  logic       valid;
  logic       ready;
  logic       brightness_write;
  logic [7:0] brightness_level;
  logic       touch_mode_write;
  logic [1:0] touch_mode;
  logic       display_enabled;
  logic [1:0] display_change;
  logic       idle_restart;

  modport source (output valid, brightness_write, brightness_level, touch_mode_write,
                  touch_mode, display_enabled, display_change, idle_restart,
                  input ready);
  modport sink   (input valid, brightness_write, brightness_level, touch_mode_write,
                  touch_mode, display_enabled, display_change, idle_restart,
                  output ready);
endinterface

@@ design/didc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// didc_cfg_regs
// Configuration registers: display timeout and user brightness.
// ----------------------------------------------------------------------------
module didc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [didc_pkg::TimeoutW-1:0] cfg_wdata,
  output didc_pkg::didc_cfg_t         cfg
);

  logic [didc_pkg::TimeoutW-1:0] timeout_r;
  logic [didc_pkg::LevelW-1:0]   bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= didc_pkg::TIMEOUT_RST;
      bright_r  <= didc_pkg::BRIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        didc_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata;
        didc_pkg::CFG_BRIGHT:  bright_r  <= cfg_wdata[didc_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.display_timeout_ms = timeout_r;
  assign cfg.user_brightness    = bright_r;

endmodule

@@ design/didc_step.sv @@
// ----------------------------------------------------------------------------
// didc_step
// One event step: next controller state and the result item.
// ----------------------------------------------------------------------------
module didc_step (
  input  didc_pkg::didc_state_t  st,
  input  didc_pkg::didc_item_t   item,
  input  didc_pkg::didc_cfg_t    cfg,
  output didc_pkg::didc_state_t  st_nxt,
  output didc_pkg::didc_result_t res
);

  logic [didc_pkg::TimeoutW-1:0] tmo;
  logic [didc_pkg::IdleW-1:0]    off_at;
  logic [didc_pkg::IdleW-1:0]    dim_at;
  logic                          idle_drop;
  logic                          touch_cyc;
  logic [9:0]                    bright_x3;
  logic [17:0]                   prod;
  logic [didc_pkg::LevelW-1:0]   dim_lvl;

  // 30% of the brightness: (b*3)/10 as (b*3*205) >> 11, exact below 1029
  assign bright_x3 = {2'b00, cfg.user_brightness} + {1'b0, cfg.user_brightness, 1'b0};
  assign prod      = {8'd0, bright_x3} * 18'd205;
  always_comb begin
    dim_lvl = {1'b0, prod[17:11]};
    if (dim_lvl == '0) dim_lvl = 8'd1;
  end

  assign tmo       = (cfg.display_timeout_ms < didc_pkg::MIN_TIMEOUT) ?
                     didc_pkg::MIN_TIMEOUT : cfg.display_timeout_ms;
  assign idle_drop = item.idle_ms < st.last_idle_ms;
  assign touch_cyc = st.cycle_is_touch | idle_drop;
  assign off_at    = touch_cyc ? didc_pkg::TOUCH_OFF_AT : {12'd0, tmo};
  assign dim_at    = touch_cyc ? didc_pkg::TOUCH_DIM_AT : {13'd0, tmo[didc_pkg::TimeoutW-1:1]};

  always_comb begin
    logic go_off;
    logic go_on;
    go_off = 1'b0;
    go_on  = 1'b0;
    st_nxt = st;
    res    = '0;

    unique case (item.req_type)
      didc_pkg::REQ_TICK: begin
        if (st.panel_on) begin
          st_nxt.cycle_is_touch = touch_cyc;
          if (idle_drop && st.is_dimmed) begin
            res.brightness_write = 1'b1;
            res.brightness_level = st.saved_brightness;
            st_nxt.is_dimmed     = 1'b0;
          end
          st_nxt.last_idle_ms = item.idle_ms;
          if (item.idle_ms >= off_at) begin
            go_off = 1'b1;
          end else if (!st_nxt.is_dimmed && item.idle_ms >= dim_at) begin
            st_nxt.saved_brightness = cfg.user_brightness;
            res.brightness_write    = 1'b1;
            res.brightness_level    = dim_lvl;
            st_nxt.is_dimmed        = 1'b1;
          end
        end
      end
      didc_pkg::REQ_TOUCH_CHK: begin
        if (st.panel_on && !st.touch_monitor_intent &&
            item.idle_ms >= didc_pkg::MONITOR_AFTER) begin
          res.touch_mode_write = 1'b1;
          res.touch_mode       = didc_pkg::MODE_MONITOR;
          if (item.mode_write_ok) st_nxt.touch_monitor_intent = 1'b1;
        end
      end
      didc_pkg::REQ_WAKE: begin
        go_on = !st.panel_on;
      end
      didc_pkg::REQ_ACTIVITY: begin
        res.idle_restart            = 1'b1;
        st_nxt.touch_monitor_intent = 1'b0;
      end
      didc_pkg::REQ_FORCE_OFF: begin
        go_off = st.panel_on;
      end
      didc_pkg::REQ_FORCE_ON: begin
        go_on = 1'b1;
      end
      default: ;
    endcase

    if (go_off) begin
      res.touch_mode_write        = 1'b1;
      res.touch_mode              = didc_pkg::MODE_SLEEP;
      res.brightness_write        = 1'b1;
      res.brightness_level        = '0;
      st_nxt.is_dimmed            = 1'b0;
      st_nxt.cycle_is_touch       = 1'b0;
      st_nxt.last_idle_ms         = '0;
      st_nxt.touch_monitor_intent = 1'b0;
      st_nxt.panel_on             = 1'b0;
      res.display_change          = didc_pkg::CHG_OFF;
    end

    if (go_on) begin
      if (!st.panel_on) begin
        st_nxt.cycle_is_touch = 1'b0;
        st_nxt.last_idle_ms   = '0;
        st_nxt.is_dimmed      = 1'b0;
        res.brightness_write  = 1'b1;
        res.brightness_level  = cfg.user_brightness;
        res.touch_mode_write  = 1'b1;
        res.touch_mode        = didc_pkg::MODE_ACTIVE;
        st_nxt.panel_on       = 1'b1;
        res.display_change    = didc_pkg::CHG_ON;
      end
      res.idle_restart            = 1'b1;
      st_nxt.touch_monitor_intent = 1'b0;
    end

    res.display_enabled = st_nxt.panel_on;
  end

endmodule

@@ design/display_idle_dim_controller.sv @@
// ----------------------------------------------------------------------------
// display_idle_dim_controller
// Event-driven display power controller: bright, dim and off cycles.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event item (tick, touch idle check, wake press,
//   activity, force off, force on) with the idle counter value. out_ch
//   returns exactly one result item per event: brightness and touch mode
//   writes, the panel on flag, the on/off change and an idle restart request.
//   cfg_we/cfg_index/cfg_wdata write the timeout (index 0) and the user
//   brightness (index 1); write them only while no item is in flight.
// Timing:
//   An accepted item lands in an input register; once the result register
//   is free the step logic loads it, and the result leaves from there when
//   out_ch.ready is high. One item per cycle is taken for as long as the
//   result register drains; the state register is updated together with
//   the result register, which allows that rate.
// Reset (rst_n low, synchronous): panel on, wake cycle, not dimmed, timeout
//   30000 ms, brightness 100, both item registers empty.
// Stall: while out_ch.ready is low the result holds, the input register
//   keeps its item and in_ch.ready drops once both registers are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module display_idle_dim_controller (
  input  logic         clk,
  input  logic         rst_n,
  didc_in_if.sink      in_ch,
  didc_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_wdata
);

  didc_pkg::didc_cfg_t    cfg;
  didc_pkg::didc_item_t   item_r;
  didc_pkg::didc_state_t  st_r;
  didc_pkg::didc_state_t  st_nxt;
  didc_pkg::didc_result_t res_nxt;
  didc_pkg::didc_result_t res_r;
  logic                   in_valid_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_take;

  didc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  didc_step u_step (
    .st     (st_r),
    .item   (item_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Move the held item into the result register when that register frees up
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take || (in_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type      <= in_ch.req_type;
      item_r.idle_ms       <= in_ch.idle_ms;
      item_r.mode_write_ok <= in_ch.mode_write_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.panel_on             <= 1'b1;
      st_r.cycle_is_touch       <= 1'b0;
      st_r.last_idle_ms         <= '0;
      st_r.is_dimmed            <= 1'b0;
      st_r.saved_brightness     <= '0;
      st_r.touch_monitor_intent <= 1'b0;
      out_valid_r               <= 1'b0;
    end else begin
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.brightness_write = res_r.brightness_write;
  assign out_ch.brightness_level = res_r.brightness_level;
  assign out_ch.touch_mode_write = res_r.touch_mode_write;
  assign out_ch.touch_mode       = res_r.touch_mode;
  assign out_ch.display_enabled  = res_r.display_enabled;
  assign out_ch.display_change   = res_r.display_change;
  assign out_ch.idle_restart     = res_r.idle_restart;

  `ASSERT_SAME(a_off_state_clean, clk, rst_n, !st_r.panel_on,
               !st_r.is_dimmed && !st_r.cycle_is_touch && !st_r.touch_monitor_intent)
  `ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance,
               out_valid_r && (out_ch.display_enabled == st_r.panel_on))
  `ASSERT_SAME(a_change_matches_flag, clk, rst_n,
               out_valid_r && (res_r.display_change != didc_pkg::CHG_NONE),
               res_r.display_enabled == (res_r.display_change == didc_pkg::CHG_ON))

endmodule
